/* rtl/nmsc_pkg.sv */
// Shared types, character codes and helpers for the NMEA sentence checker.
package nmsc_pkg;

  localparam int unsigned LINE_SIZE_DEF = 128;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4d;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam int unsigned TDATA_OUT_W = 40;

  typedef enum logic [1:0] {
    STAR_NONE = 2'd0,
    STAR_HI   = 2'd1,
    STAR_LO   = 2'd2,
    STAR_DONE = 2'd3
  } star_phase_e;

  typedef struct packed {
    logic [7:0] received_checksum;
    logic [7:0] computed_checksum;
    logic [6:0] line_length;
    logic       is_rmc;
    logic [7:0] talker_letter;
    logic       checksum_ok;
    logic       is_gnss;
  } result_t;

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c inside {[8'h30:8'h39]}) v = c[3:0];
    else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) v = c[3:0] + 4'd9;
    return v;
  endfunction

endpackage

/* rtl/nmsc_line_state.sv */
// Per-line tracking state and the single-pass update for one received byte.
module nmsc_line_state #(
  parameter int unsigned LINE_SIZE = nmsc_pkg::LINE_SIZE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              beat_i,
  input  logic [7:0]        rx_byte_i,
  output logic              res_valid_o,
  output nmsc_pkg::result_t res_o
);

  localparam int unsigned WPW = $clog2(LINE_SIZE + 1);

  logic [WPW-1:0]        wpos_q, wpos_d;
  logic [7:0]            held_q, held_d;
  logic [7:0]            xor_q, xor_d;
  nmsc_pkg::star_phase_e star_q, star_d;
  logic [7:0]            rval_q, rval_d;
  logic [1:0]            pfx_q, pfx_d;
  logic [7:0]            talker_q, talker_d;
  logic [1:0]            type_q, type_d;
  logic                  zero_q, zero_d;

  logic [WPW-1:0] pos;
  logic           restart;
  logic [WPW-1:0] len;

  assign pos = wpos_q - WPW'(1);
  assign len = wpos_q - WPW'(1);

  always_comb begin
    wpos_d   = wpos_q;
    held_d   = held_q;
    xor_d    = xor_q;
    star_d   = star_q;
    rval_d   = rval_q;
    pfx_d    = pfx_q;
    talker_d = talker_q;
    type_d   = type_q;
    zero_d   = zero_q;
    restart  = 1'b0;

    res_valid_o             = 1'b0;
    res_o.is_gnss           = (pfx_q == 2'b11);
    res_o.checksum_ok       = (star_q != nmsc_pkg::STAR_NONE) && (rval_q == xor_q);
    res_o.talker_letter     = talker_q;
    res_o.is_rmc            = (type_q == 2'd3);
    res_o.line_length       = 7'(len);
    res_o.computed_checksum = xor_q;
    res_o.received_checksum = rval_q;

    if (beat_i) begin
      if (rx_byte_i == nmsc_pkg::CH_LF) begin
        res_valid_o = (wpos_q > WPW'(1));
        restart     = 1'b1;
        wpos_d      = '0;
        held_d      = '0;
      end else if (rx_byte_i == nmsc_pkg::CH_DOLLAR || wpos_q >= WPW'(LINE_SIZE)) begin
        restart = 1'b1;
        wpos_d  = WPW'(1);
        held_d  = rx_byte_i;
      end else begin
        wpos_d = wpos_q + WPW'(1);
        held_d = rx_byte_i;
        // the held byte is now known not to be the dropped carriage return
        if (wpos_q != '0) begin
          if (pos == WPW'(0) && held_q == nmsc_pkg::CH_DOLLAR) pfx_d[0] = 1'b1;
          if (pos == WPW'(1) && held_q == nmsc_pkg::CH_G) pfx_d[1] = 1'b1;
          if (pos == WPW'(2)) talker_d = held_q;
          if (pos == WPW'(3) && held_q == nmsc_pkg::CH_R) type_d = 2'd1;
          if (pos == WPW'(4) && type_q == 2'd1 && held_q == nmsc_pkg::CH_M) type_d = 2'd2;
          if (pos == WPW'(5) && type_q == 2'd2 && held_q == nmsc_pkg::CH_C) type_d = 2'd3;
          if (pos != WPW'(0) && !zero_q) begin
            if (held_q == nmsc_pkg::CH_NUL) begin
              zero_d = 1'b1;
            end else begin
              case (star_q)
                nmsc_pkg::STAR_NONE: begin
                  if (held_q == nmsc_pkg::CH_STAR) star_d = nmsc_pkg::STAR_HI;
                  else xor_d = xor_q ^ held_q;
                end
                nmsc_pkg::STAR_HI: begin
                  rval_d = {nmsc_pkg::hex_digit(held_q), 4'd0};
                  star_d = nmsc_pkg::STAR_LO;
                end
                nmsc_pkg::STAR_LO: begin
                  rval_d = {rval_q[7:4], nmsc_pkg::hex_digit(held_q)};
                  star_d = nmsc_pkg::STAR_DONE;
                end
                default: ;
              endcase
            end
          end
        end
      end

      if (restart) begin
        xor_d    = '0;
        star_d   = nmsc_pkg::STAR_NONE;
        rval_d   = '0;
        pfx_d    = '0;
        talker_d = '0;
        type_d   = '0;
        zero_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q   <= '0;
      held_q   <= '0;
      xor_q    <= '0;
      star_q   <= nmsc_pkg::STAR_NONE;
      rval_q   <= '0;
      pfx_q    <= '0;
      talker_q <= '0;
      type_q   <= '0;
      zero_q   <= 1'b0;
    end else begin
      wpos_q   <= wpos_d;
      held_q   <= held_d;
      xor_q    <= xor_d;
      star_q   <= star_d;
      rval_q   <= rval_d;
      pfx_q    <= pfx_d;
      talker_q <= talker_d;
      type_q   <= type_d;
      zero_q   <= zero_d;
    end
  end

endmodule

/* rtl/nmsc_out_buf.sv */
// Result register with a skid stage so input keeps flowing while a result waits.
module nmsc_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  nmsc_pkg::result_t in_data_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output nmsc_pkg::result_t out_data_o,
  input  logic              out_ready_i
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  nmsc_pkg::result_t out_q, out_d;
  nmsc_pkg::result_t skid_q, skid_d;
  logic              pop;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pop         = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_valid_i) begin
      if (!out_valid_q || pop) begin
        out_d       = in_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = in_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

/* rtl/nmea_sentence_checker.sv */
// Top level of the NMEA sentence checker.
// One received byte is taken per beat, every cycle that the input is ready, and
// checked on the fly: the running XOR, star and hex-digit tracking, prefix and RMC
// tests all update together from the line state registers, so no line buffer is kept.
// A newline that closes a line of two or more collected bytes (the last one, the
// carriage return, is dropped) yields one result beat. It is registered in the result
// register or, while that one waits, in the one-beat skid stage that backs it, so the
// input stalls only when two results are waiting downstream. A dollar sign, or a byte
// arriving with LINE_SIZE bytes already held, restarts the line.
module nmea_sentence_checker #(
  parameter int unsigned LINE_SIZE = nmsc_pkg::LINE_SIZE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [7:0]                       s_axis_tdata_i,  // [7:0] rx_byte
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [0] is_gnss, [1] checksum_ok, [9:2] talker_letter, [10] is_rmc,
  // [17:11] line_length, [25:18] computed_checksum, [33:26] received_checksum
  output logic [nmsc_pkg::TDATA_OUT_W-1:0] m_axis_tdata_o
);

  logic              beat;
  logic              res_valid;
  nmsc_pkg::result_t res;
  nmsc_pkg::result_t out_res;

  assign beat = s_axis_tvalid_i && s_axis_tready_o;

  nmsc_line_state #(
    .LINE_SIZE(LINE_SIZE)
  ) u_line (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .beat_i     (beat),
    .rx_byte_i  (s_axis_tdata_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  nmsc_out_buf u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (res_valid),
    .in_data_i  (res),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_data_o (out_res),
    .out_ready_i(m_axis_tready_i)
  );

  assign m_axis_tdata_o = {
    {(nmsc_pkg::TDATA_OUT_W - $bits(nmsc_pkg::result_t)){1'b0}}, out_res
  };

endmodule
